// ===== design/ipsa_pkg.sv =====
// package for the interlace phase shift average block
// shared constants, register codes and the cordic arctangent table; no dependencies
package ipsa_pkg;

   localparam int IDX_W         = 10;
   localparam int CFG_W         = 11;
   localparam int ANG_W         = 32;
   localparam int ANG_FRAC      = 31;
   localparam int TRIG_W        = 16;
   localparam int XY_W          = 18;
   localparam int Z_W           = 34;
   localparam int CORDIC_STAGES = 16;
   localparam int CORDIC_START  = 19898;
   localparam int TRIG_MAX      = 32767;
   localparam int GRID_DEF      = 256;
   localparam int MAX_GRID_DEF  = 1024;
   localparam int DATA_W_DEF    = 32;
   localparam int DIV_STAGES    = IDX_W + ANG_FRAC;

   typedef enum logic [1:0] {
      REG_GRID_X = 2'd0,
      REG_GRID_Y = 2'd1,
      REG_GRID_Z = 2'd2
   } csr_index_type;

   // arctangent of 2^-k in units of 2^-32 turn
   function automatic logic signed [Z_W-1:0] atan_turns(input int k);
      logic signed [Z_W-1:0] a;
      case (k)
         0:  a = 34'sd536870912;
         1:  a = 34'sd316933406;
         2:  a = 34'sd167458907;
         3:  a = 34'sd85004756;
         4:  a = 34'sd42667331;
         5:  a = 34'sd21354465;
         6:  a = 34'sd10679838;
         7:  a = 34'sd5340245;
         8:  a = 34'sd2670163;
         9:  a = 34'sd1335087;
         10: a = 34'sd667544;
         11: a = 34'sd333772;
         12: a = 34'sd166886;
         13: a = 34'sd83443;
         14: a = 34'sd41722;
         default: a = 34'sd20861;
      endcase
      return a;
   endfunction

endpackage

// ===== design/ipsa_div_cell.sv =====
// one restoring-division cell: one quotient bit of index * 2^31 / grid per cycle while adv is high
// depends on ipsa_pkg
module ipsa_div_cell #(
   parameter int STAGE  = 0,
   parameter int GRID_W = 11
) (
   input  logic                         clock,
   input  logic                         adv,
   input  logic [GRID_W-1:0]            grid,
   input  logic [ipsa_pkg::IDX_W-1:0]   idx_in,
   input  logic [GRID_W-1:0]            rem_in,
   input  logic [ipsa_pkg::ANG_W-1:0]   quot_in,
   output logic [ipsa_pkg::IDX_W-1:0]   idx_ff,
   output logic [GRID_W-1:0]            rem_ff,
   output logic [ipsa_pkg::ANG_W-1:0]   quot_ff
);
   import ipsa_pkg::*;

   localparam int POS = DIV_STAGES - 1 - STAGE;

   logic              dbit;
   logic [GRID_W:0]   trial;
   logic              ge;
   logic [GRID_W:0]   diff;
   logic [GRID_W-1:0] rem_in_n;

   // dividend bit: index bits on top, zeros below
   generate
      if (POS >= ANG_FRAC) begin : g_idx_bit
         assign dbit = idx_in[POS-ANG_FRAC];
      end else begin : g_zero_bit
         assign dbit = 1'b0;
      end
   endgenerate

   // shift in, compare, subtract
   always_comb begin
      trial    = {rem_in, dbit};
      ge       = (trial >= {1'b0, grid});
      diff     = trial - {1'b0, grid};
      rem_in_n = ge ? diff[GRID_W-1:0] : trial[GRID_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         idx_ff  <= idx_in;
         rem_ff  <= rem_in_n;
         quot_ff <= {quot_in[ANG_W-2:0], ge};
      end
   end

endmodule

// ===== design/ipsa_cordic_cell.sv =====
// one cordic rotation cell, one micro-rotation per cycle while adv is high
// depends on ipsa_pkg
module ipsa_cordic_cell #(
   parameter int STAGE = 0
) (
   input  logic                               clock,
   input  logic                               adv,
   input  logic signed [ipsa_pkg::XY_W-1:0]   x_in,
   input  logic signed [ipsa_pkg::XY_W-1:0]   y_in,
   input  logic signed [ipsa_pkg::Z_W-1:0]    z_in,
   input  logic                               flip_in,
   output logic signed [ipsa_pkg::XY_W-1:0]   x_ff,
   output logic signed [ipsa_pkg::XY_W-1:0]   y_ff,
   output logic signed [ipsa_pkg::Z_W-1:0]    z_ff,
   output logic                               flip_ff
);
   import ipsa_pkg::*;

   logic signed [XY_W-1:0] xs;
   logic signed [XY_W-1:0] ys;
   logic signed [XY_W-1:0] x_in_n;
   logic signed [XY_W-1:0] y_in_n;
   logic signed [Z_W-1:0]  z_in_n;

   // rotate toward zero residual angle
   always_comb begin
      xs = x_in >>> STAGE;
      ys = y_in >>> STAGE;
      if (!z_in[Z_W-1]) begin
         x_in_n = x_in - ys;
         y_in_n = y_in + xs;
         z_in_n = z_in - atan_turns(STAGE);
      end else begin
         x_in_n = x_in + ys;
         y_in_n = y_in - xs;
         z_in_n = z_in + atan_turns(STAGE);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff    <= x_in_n;
         y_ff    <= y_in_n;
         z_ff    <= z_in_n;
         flip_ff <= flip_in;
      end
   end

endmodule

// ===== design/interlace_phase_shift_average_core.sv =====
// throughput: one beat per cycle while the row is not held; 41 division cells per axis and 16 cordic cells in a row
// the whole row holds while an rsp beat waits under rsp_stall
// reset: synchronous, active high; clears valid bits and sets grid sizes to 256
// top level; depends on ipsa_pkg, ipsa_div_cell, ipsa_cordic_cell
module interlace_phase_shift_average_core #(
   parameter int MAX_GRID   = ipsa_pkg::MAX_GRID_DEF,
   parameter int DATA_WIDTH = ipsa_pkg::DATA_W_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [DATA_WIDTH-1:0]       req_first_re,
   input  logic signed [DATA_WIDTH-1:0]       req_first_im,
   input  logic signed [DATA_WIDTH-1:0]       req_second_re,
   input  logic signed [DATA_WIDTH-1:0]       req_second_im,
   input  logic [ipsa_pkg::IDX_W-1:0]         req_index_x,
   input  logic [ipsa_pkg::IDX_W-1:0]         req_index_y,
   input  logic [ipsa_pkg::IDX_W-1:0]         req_index_z,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [DATA_WIDTH-1:0]       rsp_avg_re,
   output logic signed [DATA_WIDTH-1:0]       rsp_avg_im,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [1:0]                         csr_index,
   input  logic [ipsa_pkg::CFG_W-1:0]         csr_data
);
   import ipsa_pkg::*;

   localparam int GRID_W = $clog2(MAX_GRID + 1);
   localparam int DLY    = DIV_STAGES + 2 + CORDIC_STAGES + 1;
   localparam int NSTAGE = DLY + 2;
   localparam int PROD_W = DATA_WIDTH + TRIG_W;
   localparam int ROT_W  = PROD_W + 1;
   localparam int SUM_W  = DATA_WIDTH + 19;
   localparam int RES_W  = SUM_W - 16;

   function automatic logic [GRID_W-1:0] eff_grid(input logic [CFG_W-1:0] v);
      logic [GRID_W-1:0] g;
      if (v == '0) begin
         g = GRID_W'(1);
      end else if (int'(v) > MAX_GRID) begin
         g = GRID_W'(MAX_GRID);
      end else begin
         g = GRID_W'(v);
      end
      return g;
   endfunction

   function automatic logic signed [TRIG_W-1:0] sat_trig(input logic signed [XY_W-1:0] v);
      logic signed [TRIG_W-1:0] r;
      if (v > XY_W'(TRIG_MAX)) begin
         r = TRIG_W'(TRIG_MAX);
      end else if (v < -XY_W'(TRIG_MAX)) begin
         r = -TRIG_W'(TRIG_MAX);
      end else begin
         r = v[TRIG_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [DATA_WIDTH-1:0] average(
      input logic signed [DATA_WIDTH-1:0] f,
      input logic signed [ROT_W-1:0]      rot
   );
      logic signed [SUM_W-1:0] t;
      logic signed [RES_W-1:0] r;
      logic signed [RES_W-1:0] hi;
      logic signed [RES_W-1:0] lo;
      logic signed [DATA_WIDTH-1:0] o;
      t  = (SUM_W'(f) <<< 15) + SUM_W'(rot) + SUM_W'(32768);
      r  = RES_W'(t >>> 16);
      hi = RES_W'({1'b0, {(DATA_WIDTH-1){1'b1}}});
      lo = ~hi;
      if (r > hi) begin
         o = hi[DATA_WIDTH-1:0];
      end else if (r < lo) begin
         o = lo[DATA_WIDTH-1:0];
      end else begin
         o = r[DATA_WIDTH-1:0];
      end
      return o;
   endfunction

   logic                    adv;
   logic [NSTAGE-1:0]       vld_ff;
   logic [GRID_W-1:0]       grid_ff [3];
   csr_index_type           csr_sel;

   // handshake: the row moves unless a finished beat is held
   assign adv       = !(vld_ff[NSTAGE-1] && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[NSTAGE-1];
   assign csr_ready = 1'b1;
   assign csr_sel   = csr_index_type'(csr_index);

   // grid size registers, stored already clamped
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_ff[0] <= eff_grid(CFG_W'(GRID_DEF));
         grid_ff[1] <= eff_grid(CFG_W'(GRID_DEF));
         grid_ff[2] <= eff_grid(CFG_W'(GRID_DEF));
      end else if (csr_valid && csr_ready) begin
         unique case (csr_sel)
            REG_GRID_X: grid_ff[0] <= eff_grid(csr_data);
            REG_GRID_Y: grid_ff[1] <= eff_grid(csr_data);
            REG_GRID_Z: grid_ff[2] <= eff_grid(csr_data);
            default: ;
         endcase
      end
   end

   // valid bits along the row
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NSTAGE-2:0], req_valid};
      end
   end

   // spectrum delay line alongside the phase path
   logic signed [DATA_WIDTH-1:0] fr_ff [DLY];
   logic signed [DATA_WIDTH-1:0] fi_ff [DLY];
   logic signed [DATA_WIDTH-1:0] sr_ff [DLY];
   logic signed [DATA_WIDTH-1:0] si_ff [DLY];

   always_ff @(posedge clock) begin
      if (adv) begin
         fr_ff[0] <= req_first_re;
         fi_ff[0] <= req_first_im;
         sr_ff[0] <= req_second_re;
         si_ff[0] <= req_second_im;
         for (int i = 1; i < DLY; i++) begin
            fr_ff[i] <= fr_ff[i-1];
            fi_ff[i] <= fi_ff[i-1];
            sr_ff[i] <= sr_ff[i-1];
            si_ff[i] <= si_ff[i-1];
         end
      end
   end

   // division rows, one per axis
   logic [IDX_W-1:0]  idx_w  [3][DIV_STAGES+1];
   logic [GRID_W-1:0] rem_w  [3][DIV_STAGES+1];
   logic [ANG_W-1:0]  quot_w [3][DIV_STAGES+1];

   assign idx_w[0][0] = req_index_x;
   assign idx_w[1][0] = req_index_y;
   assign idx_w[2][0] = req_index_z;

   generate
      for (genvar a = 0; a < 3; a++) begin : g_axis
         assign rem_w[a][0]  = '0;
         assign quot_w[a][0] = '0;
         for (genvar k = 0; k < DIV_STAGES; k++) begin : g_cell
            ipsa_div_cell #(.STAGE(k), .GRID_W(GRID_W)) u_div (
               .clock   (clock),
               .adv     (adv),
               .grid    (grid_ff[a]),
               .idx_in  (idx_w[a][k]),
               .rem_in  (rem_w[a][k]),
               .quot_in (quot_w[a][k]),
               .idx_ff  (idx_w[a][k+1]),
               .rem_ff  (rem_w[a][k+1]),
               .quot_ff (quot_w[a][k+1])
            );
         end
      end
   endgenerate

   // phase angle is minus the sum of the axis terms
   logic [ANG_W-1:0] ang_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         ang_ff <= ANG_W'(0) - (quot_w[0][DIV_STAGES] + quot_w[1][DIV_STAGES]
                              + quot_w[2][DIV_STAGES]);
      end
   end

   // fold into the right half plane
   logic signed [Z_W-1:0]  z0;
   logic signed [Z_W-1:0]  z_pre;
   logic                   flip_pre;
   logic signed [XY_W-1:0] cx_w [CORDIC_STAGES+1];
   logic signed [XY_W-1:0] cy_w [CORDIC_STAGES+1];
   logic signed [Z_W-1:0]  cz_w [CORDIC_STAGES+1];
   logic                   cf_w [CORDIC_STAGES+1];

   always_comb begin
      z0 = Z_W'($signed(ang_ff));
      if (z0 > Z_W'(64'sd1073741824)) begin
         z_pre    = z0 - Z_W'(64'sd2147483648);
         flip_pre = 1'b1;
      end else if (z0 < -Z_W'(64'sd1073741824)) begin
         z_pre    = z0 + Z_W'(64'sd2147483648);
         flip_pre = 1'b1;
      end else begin
         z_pre    = z0;
         flip_pre = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cx_w[0] <= XY_W'(CORDIC_START);
         cy_w[0] <= '0;
         cz_w[0] <= z_pre;
         cf_w[0] <= flip_pre;
      end
   end

   // cordic row
   generate
      for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
         ipsa_cordic_cell #(.STAGE(k)) u_cordic (
            .clock   (clock),
            .adv     (adv),
            .x_in    (cx_w[k]),
            .y_in    (cy_w[k]),
            .z_in    (cz_w[k]),
            .flip_in (cf_w[k]),
            .x_ff    (cx_w[k+1]),
            .y_ff    (cy_w[k+1]),
            .z_ff    (cz_w[k+1]),
            .flip_ff (cf_w[k+1])
         );
      end
   endgenerate

   // unfold and clamp cosine and sine
   logic signed [TRIG_W-1:0] cos_ff;
   logic signed [TRIG_W-1:0] sin_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         if (cf_w[CORDIC_STAGES]) begin
            cos_ff <= sat_trig(-cx_w[CORDIC_STAGES]);
            sin_ff <= sat_trig(-cy_w[CORDIC_STAGES]);
         end else begin
            cos_ff <= sat_trig(cx_w[CORDIC_STAGES]);
            sin_ff <= sat_trig(cy_w[CORDIC_STAGES]);
         end
      end
   end

   // products of the rotation
   logic signed [PROD_W-1:0]     p_rc_ff, p_is_ff, p_rs_ff, p_ic_ff;
   logic signed [DATA_WIDTH-1:0] f_re_ff, f_im_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         p_rc_ff <= sr_ff[DLY-1] * cos_ff;
         p_is_ff <= si_ff[DLY-1] * sin_ff;
         p_rs_ff <= sr_ff[DLY-1] * sin_ff;
         p_ic_ff <= si_ff[DLY-1] * cos_ff;
         f_re_ff <= fr_ff[DLY-1];
         f_im_ff <= fi_ff[DLY-1];
      end
   end

   // sum, halve with rounding, saturate into the output register
   logic signed [ROT_W-1:0] rot_re;
   logic signed [ROT_W-1:0] rot_im;
   assign rot_re = ROT_W'(p_rc_ff) - ROT_W'(p_is_ff);
   assign rot_im = ROT_W'(p_rs_ff) + ROT_W'(p_ic_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_avg_re <= average(f_re_ff, rot_re);
         rsp_avg_im <= average(f_im_ff, rot_im);
      end
   end

endmodule

// ===== design/ipsa_checker.sv =====
// port-level checks for the interlace phase shift average core, with its bind
// depends on ipsa_pkg and interlace_phase_shift_average_core
module ipsa_checker #(
   parameter int DATA_WIDTH = ipsa_pkg::DATA_W_DEF
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [DATA_WIDTH-1:0] rsp_avg_re,
   input logic [DATA_WIDTH-1:0] rsp_avg_im,
   input logic                  csr_ready
);
   import ipsa_pkg::*;

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp beat right after reset");

   // the input side only stalls while an output beat is held
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req stalled without held rsp beat");

   // a held beat stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_avg_re) && $stable(rsp_avg_im)))
      else $error("held rsp beat changed");

   // configuration is always taken
   a_csr_ready: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("csr not ready");

endmodule

bind interlace_phase_shift_average_core ipsa_checker #(.DATA_WIDTH(DATA_WIDTH)) u_ipsa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_avg_re (rsp_avg_re),
   .rsp_avg_im (rsp_avg_im),
   .csr_ready  (csr_ready)
);
